// ===== sv/lkv_pkg.sv =====
// Shared types and constants of the LRU key/value cache.
package lkv_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned KeyBitsDef    = 64;
  localparam int unsigned KeyFieldW     = 64;
  localparam int unsigned ValW          = 32;
  localparam int unsigned CapW          = 5;
  localparam int unsigned OccW          = 5;
  localparam logic [CapW-1:0] CapReset  = 5'd16;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdLookup = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StApply,
    StReply
  } lkv_state_e;

  typedef struct packed {
    logic load;
    logic search;
    logic apply;
    logic reply;
  } lkv_cmd_t;

endpackage

// ===== sv/lkv_ram.sv =====
// Generic single-port RAM with registered read.
module lkv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lkv_ctrl.sv =====
// Sequencing state machine of the LRU key/value cache.
module lkv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output lkv_pkg::lkv_cmd_t cmd_o
);

  import lkv_pkg::*;

  lkv_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StSearch;
        end
      end
      StSearch: begin
        cmd_o.search = 1'b1;
        state_d      = StApply;
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        state_d     = StReply;
      end
      StReply: begin
        cmd_o.reply = 1'b1;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== sv/lkv_datapath.sv =====
// Entry store, key match, recency ranks and eviction of the LRU key/value cache.
module lkv_datapath #(
  parameter int unsigned MaxEntries = lkv_pkg::MaxEntriesDef,
  parameter int unsigned KeyBits    = lkv_pkg::KeyBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lkv_pkg::lkv_cmd_t                 cmd_i,
  input  logic                              command_i,
  input  logic [lkv_pkg::KeyFieldW-1:0]     key_i,
  input  logic signed [lkv_pkg::ValW-1:0]   write_value_i,
  input  logic                              cfg_we_i,
  input  logic [lkv_pkg::CapW-1:0]          cfg_capacity_i,
  output logic                              found_o,
  output logic signed [lkv_pkg::ValW-1:0]   read_value_o,
  output logic                              evicted_o,
  output logic [lkv_pkg::KeyFieldW-1:0]     most_recent_key_o,
  output logic [lkv_pkg::OccW-1:0]          occupancy_o
);

  import lkv_pkg::*;

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam logic [7:0]  Max8 = 8'(MaxEntries);

  logic                  req_cmd_q;
  logic [KeyBits-1:0]    req_key_q;
  logic [ValW-1:0]       req_wval_q;
  logic [CapW-1:0]       cap_q;
  logic [MaxEntries-1:0] valid_q;
  logic [IdxW-1:0]       rank_q [MaxEntries];
  logic [KeyBits-1:0]    keys_q [MaxEntries];
  logic [CntW-1:0]       count_q;
  logic [KeyBits-1:0]    mrk_q;
  logic                  hit_q;
  logic [IdxW-1:0]       hit_idx_q;
  logic [IdxW-1:0]       hit_rank_q;
  logic                  evicted_q;

  logic [MaxEntries-1:0] match_c;
  logic                  hit_c;
  logic [IdxW-1:0]       hit_idx_c;
  logic [IdxW-1:0]       hit_rank_c;
  logic [IdxW-1:0]       free_idx_c;
  logic [CntW-1:0]       cap_used_c;
  logic                  evict_c;

  logic                  ram_we;
  logic                  ram_re;
  logic [IdxW-1:0]       ram_addr;
  logic [ValW-1:0]       ram_rdata;

  always_comb begin
    if (cap_q == '0) begin
      cap_used_c = CntW'(1);
    end else if (8'(cap_q) > Max8) begin
      cap_used_c = CntW'(MaxEntries);
    end else begin
      cap_used_c = CntW'(cap_q);
    end
  end

  always_comb begin
    hit_idx_c  = '0;
    hit_rank_c = '0;
    free_idx_c = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      match_c[i] = valid_q[i] && (keys_q[i] == req_key_q);
      if (match_c[i]) begin
        hit_rank_c = hit_rank_c | rank_q[i];
      end
    end
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (match_c[i]) begin
        hit_idx_c = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_idx_c = IdxW'(i);
      end
    end
    hit_c   = |match_c;
    evict_c = (req_cmd_q == CmdInsert) && !hit_c && (count_q >= cap_used_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CapReset;
      valid_q   <= '0;
      count_q   <= '0;
      mrk_q     <= '0;
      hit_q     <= 1'b0;
      evicted_q <= 1'b0;
      for (int i = 0; i < MaxEntries; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_capacity_i;
      end
      if (cmd_i.search) begin
        hit_q     <= hit_c;
        evicted_q <= evict_c;
        if (evict_c) begin
          // ranks of valid entries are distinct, so cap_used-1 entries remain
          for (int i = 0; i < MaxEntries; i++) begin
            if (valid_q[i] && (CntW'(rank_q[i]) >= cap_used_c - CntW'(1))) begin
              valid_q[i] <= 1'b0;
              rank_q[i]  <= '0;
            end
          end
          count_q <= cap_used_c - CntW'(1);
        end
      end
      if (cmd_i.apply) begin
        if (hit_q) begin
          for (int i = 0; i < MaxEntries; i++) begin
            if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
              rank_q[i] <= rank_q[i] + IdxW'(1);
            end
          end
          rank_q[hit_idx_q] <= '0;
          mrk_q             <= req_key_q;
        end else if (req_cmd_q == CmdInsert) begin
          for (int i = 0; i < MaxEntries; i++) begin
            if (valid_q[i]) begin
              rank_q[i] <= rank_q[i] + IdxW'(1);
            end
          end
          valid_q[free_idx_c] <= 1'b1;
          rank_q[free_idx_c]  <= '0;
          count_q             <= count_q + CntW'(1);
          mrk_q               <= req_key_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_cmd_q  <= command_i;
      req_key_q  <= key_i[KeyBits-1:0];
      req_wval_q <= write_value_i;
    end
    if (cmd_i.search) begin
      hit_idx_q  <= hit_idx_c;
      hit_rank_q <= hit_rank_c;
    end
    if (cmd_i.apply && !hit_q && (req_cmd_q == CmdInsert)) begin
      keys_q[free_idx_c] <= req_key_q;
    end
  end

  assign ram_we   = cmd_i.apply && (req_cmd_q == CmdInsert);
  assign ram_re   = cmd_i.apply && (req_cmd_q == CmdLookup) && hit_q;
  assign ram_addr = hit_q ? hit_idx_q : free_idx_c;

  lkv_ram #(
    .Width(ValW),
    .Depth(MaxEntries)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(req_wval_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (req_cmd_q == CmdInsert) begin
      read_value_o = req_wval_q;
    end else if (hit_q) begin
      read_value_o = ram_rdata;
    end else begin
      read_value_o = '0;
    end
  end

  assign found_o           = hit_q;
  assign evicted_o         = evicted_q;
  assign most_recent_key_o = KeyFieldW'(mrk_q);
  assign occupancy_o       = OccW'(count_q);

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Top level of the fully associative key/value cache with LRU replacement.
//
// Requests: a transfer happens at a rising edge with start high and busy low;
// command_i selects insert/update or lookup, key_i and write_value_i carry
// the payload. busy stays high while a request is in progress.
// Results: done_o is high for exactly one cycle with found_o, read_value_o,
// evicted_o, most_recent_key_o and occupancy_o valid; the receiver takes the
// transfer in that cycle and has no way to hold it off.
// Timing: done_o rises in the reply state, after the search and apply states;
// a new request is taken in the cycle after done_o, so the block handles
// one request at a time, set by the single-request state machine and the
// registered read of the value RAM.
// Capacity: cfg_we_i writes cfg_capacity_i; it is used clamped to
// 1..MaxEntries; it must be written only while busy is low (not enforced).
// Reset: rst_ni clears all entries, the occupancy and the most recent key,
// and sets the capacity to 16; the cache takes requests at once.
module lru_key_value_cache #(
  parameter int unsigned MaxEntries = lkv_pkg::MaxEntriesDef,
  parameter int unsigned KeyBits    = lkv_pkg::KeyBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command_i,
  input  logic [lkv_pkg::KeyFieldW-1:0]   key_i,
  input  logic signed [lkv_pkg::ValW-1:0] write_value_i,
  input  logic                            cfg_we_i,
  input  logic [lkv_pkg::CapW-1:0]        cfg_capacity_i,
  output logic                            done_o,
  output logic                            found_o,
  output logic signed [lkv_pkg::ValW-1:0] read_value_o,
  output logic                            evicted_o,
  output logic [lkv_pkg::KeyFieldW-1:0]   most_recent_key_o,
  output logic [lkv_pkg::OccW-1:0]        occupancy_o
);

  import lkv_pkg::*;

  lkv_cmd_t cmd;

  lkv_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_o (cmd)
  );

  lkv_datapath #(
    .MaxEntries(MaxEntries),
    .KeyBits   (KeyBits)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .command_i        (command_i),
    .key_i            (key_i),
    .write_value_i    (write_value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_capacity_i   (cfg_capacity_i),
    .found_o          (found_o),
    .read_value_o     (read_value_o),
    .evicted_o        (evicted_o),
    .most_recent_key_o(most_recent_key_o),
    .occupancy_o      (occupancy_o)
  );

  assign done_o = cmd.reply;

endmodule

// ===== sim/lru_key_value_cache_test.sv =====
// Self-checking testbench for lru_key_value_cache: directed and random insert/lookup traffic.
package lru_kv_check_pkg;
  import lkv_pkg::*;

  typedef struct packed {
    logic                 found;
    logic [ValW-1:0]      read_value;
    logic                 evicted;
    logic [KeyFieldW-1:0] mru_key;
    logic [OccW-1:0]      occupancy;
  } cache_reply_t;

  class lru_cache_mirror;
    logic [KeyFieldW-1:0] slot_key [MaxEntriesDef];
    logic [ValW-1:0]      slot_val [MaxEntriesDef];
    bit                   slot_live [MaxEntriesDef];
    int unsigned          slot_rank [MaxEntriesDef];
    int unsigned          live_count;
    logic [CapW-1:0]      cap_reg;
    cache_reply_t         replies_due[$];
    int unsigned          mismatches;

    function new();
      for (int i = 0; i < MaxEntriesDef; i++) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
        slot_live[i] = 1'b0;
        slot_rank[i] = 0;
      end
      live_count = 0;
      cap_reg = CapReset;
      mismatches = 0;
    endfunction

    function void load_capacity(logic [CapW-1:0] v);
      cap_reg = v;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    // Work out the reply for one accepted request and update the mirrored state.
    function void note_request(logic cmd, logic [KeyFieldW-1:0] key, logic [ValW-1:0] wval);
      cache_reply_t r;
      bit           hit;
      int unsigned  h;
      int unsigned  cap;
      int unsigned  slot;
      int unsigned  rank;
      r = '0;
      hit = 1'b0;
      h = 0;
      for (int i = 0; i < MaxEntriesDef; i++)
        if (!hit && slot_live[i] && slot_key[i] == key) begin
          hit = 1'b1;
          h = i;
        end
      if (hit) begin
        if (cmd == CmdInsert) slot_val[h] = wval;
        r.read_value = slot_val[h];
        rank = slot_rank[h];
        for (int i = 0; i < MaxEntriesDef; i++)
          if (slot_live[i] && slot_rank[i] < rank) slot_rank[i]++;
        slot_rank[h] = 0;
      end else if (cmd == CmdInsert) begin
        if (cap_reg == 0) cap = 1;
        else if (cap_reg > MaxEntriesDef) cap = MaxEntriesDef;
        else cap = cap_reg;
        if (live_count >= cap) begin
          // may drop several entries when the capacity was lowered
          for (int i = 0; i < MaxEntriesDef; i++)
            if (slot_live[i] && slot_rank[i] >= cap - 1) begin
              slot_live[i] = 1'b0;
              slot_rank[i] = 0;
              live_count--;
              r.evicted = 1'b1;
            end
        end
        slot = MaxEntriesDef;
        for (int i = 0; i < MaxEntriesDef; i++)
          if (!slot_live[i] && slot == MaxEntriesDef) slot = i;
        if (slot < MaxEntriesDef) begin
          for (int i = 0; i < MaxEntriesDef; i++)
            if (slot_live[i]) slot_rank[i]++;
          slot_live[slot] = 1'b1;
          slot_key[slot] = key;
          slot_val[slot] = wval;
          slot_rank[slot] = 0;
          live_count++;
        end
        r.read_value = wval;
      end
      r.found = hit;
      for (int i = MaxEntriesDef - 1; i >= 0; i--)
        if (slot_live[i] && slot_rank[i] == 0) r.mru_key = slot_key[i];
      r.occupancy = live_count[OccW-1:0];
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic found, logic [ValW-1:0] rval, logic evicted,
                              logic [KeyFieldW-1:0] mru_key, logic [OccW-1:0] occupancy);
      cache_reply_t want;
      if (replies_due.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        mismatches++;
      end
      if (rval !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", $signed(want.read_value), $signed(rval));
        mismatches++;
      end
      if (evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, evicted);
        mismatches++;
      end
      if (mru_key !== want.mru_key) begin
        $error("most_recent_key: expected %h, got %h", want.mru_key, mru_key);
        mismatches++;
      end
      if (occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
        mismatches++;
      end
    endfunction
  endclass
endpackage

module lru_key_value_cache_test;
  import lkv_pkg::*;
  import lru_kv_check_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned PhaseItems  = 104;
  localparam int unsigned PoolSize    = 24;
  localparam int unsigned NumPhases   = 8;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   command_i = CmdInsert;
  logic [KeyFieldW-1:0]   key_i = '0;
  logic signed [ValW-1:0] write_value_i = '0;
  logic                   cfg_we_i = 1'b0;
  logic [CapW-1:0]        cfg_capacity_i = '0;
  logic                   busy;
  logic                   done_o;
  logic                   found_o;
  logic signed [ValW-1:0] read_value_o;
  logic                   evicted_o;
  logic [KeyFieldW-1:0]   most_recent_key_o;
  logic [OccW-1:0]        occupancy_o;

  lru_cache_mirror      mirror;
  int unsigned          idle_pct = 0;
  int unsigned          stall_cycles = 0;
  logic [KeyFieldW-1:0] key_pool [PoolSize];

  lru_key_value_cache u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .key_i             (key_i),
    .write_value_i     (write_value_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_capacity_i    (cfg_capacity_i),
    .done_o            (done_o),
    .found_o           (found_o),
    .read_value_o      (read_value_o),
    .evicted_o         (evicted_o),
    .most_recent_key_o (most_recent_key_o),
    .occupancy_o       (occupancy_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && mirror != null) begin
      if (cfg_we_i) mirror.load_capacity(cfg_capacity_i);
      if (done_o) mirror.check_reply(found_o, read_value_o, evicted_o, most_recent_key_o,
                                     occupancy_o);
      if (start && !busy) mirror.note_request(command_i, key_i, write_value_i);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(logic cmd, logic [KeyFieldW-1:0] key, logic [ValW-1:0] wval);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    key_i <= key;
    write_value_i <= wval;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CapW-1:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_capacity_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly keys from a small pool so that hits, updates and evictions are common.
  task automatic random_requests(int unsigned count);
    logic [KeyFieldW-1:0] key;
    logic                 cmd;
    for (int unsigned n = 0; n < count; n++) begin
      cmd = ($urandom_range(1) == 0) ? CmdInsert : CmdLookup;
      if ($urandom_range(4) == 0) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(PoolSize - 1)];
      send_request(cmd, key, $urandom);
    end
  endtask

  initial begin
    int unsigned          phase_idle [NumPhases];
    logic [CapW-1:0]      phase_cap [NumPhases];
    mirror = new();
    phase_idle = '{0, 79, 10, 0, 79, 30, 10, 0};
    phase_cap = '{5'd16, 5'd2, 5'd1, 5'd5, 5'd20, 5'd8, 5'd0, 5'd16};
    phase_cap[6] = CapW'($urandom_range(31));
    for (int i = 0; i < PoolSize; i++) key_pool[i] = {$urandom, $urandom};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty store, extreme keys and values, update and lookup paths
    send_request(CmdLookup, '0, '0);
    send_request(CmdInsert, '0, 32'h8000_0000);
    send_request(CmdInsert, '1, 32'h7fff_ffff);
    send_request(CmdLookup, '0, 32'h1);
    send_request(CmdInsert, '0, '1);
    send_request(CmdLookup, '1, '0);
    send_request(CmdLookup, 64'h5, '0);
    for (int k = 0; k < 14; k++) send_request(CmdInsert, 64'h100 + k, k);
    send_request(CmdInsert, 64'h200, 32'h1234);
    // capacity lowered below occupancy: next new key drops many at once
    write_capacity(5'd3);
    send_request(CmdInsert, 64'h300, 32'h55);
    send_request(CmdLookup, 64'h200, '0);
    write_capacity(5'd0);
    send_request(CmdInsert, 64'h400, 32'h66);
    send_request(CmdInsert, 64'h401, 32'h77);
    write_capacity(5'd31);
    send_request(CmdInsert, 64'h402, 32'h88);

    for (int p = 0; p < NumPhases; p++) begin
      write_capacity(phase_cap[p]);
      idle_pct = phase_idle[p];
      random_requests(PhaseItems);
    end
    idle_pct = 0;
    settle();

    if (mirror.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/lkv_pkg.sv
sv/lkv_ram.sv
sv/lkv_ctrl.sv
sv/lkv_datapath.sv
sv/lru_key_value_cache.sv
sim/lru_key_value_cache_test.sv
